@@ design/mfd_pkg.sv @@
// Shared types and constants for the meter frame decoder.
package mfd_pkg;

	localparam int FrameLen = 14;
	localparam int PosW     = $clog2(FrameLen + 1);
	localparam int QueueDepth = 2;

	typedef logic [FrameLen-1:0][7:0] frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ design/mfd_front.sv @@
// Frame assembler: collects report bytes and hands each completed frame to the queue.
module mfd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       rx_byte,
	input  logic             frame_start,
	input  mfd_pkg::q_stat_t q_stat,
	output logic             push,
	output mfd_pkg::frame_t  push_frame
);
	import mfd_pkg::*;

	localparam logic [PosW-1:0] LastPos = PosW'(FrameLen - 1);
	localparam logic [PosW-1:0] EndPos  = PosW'(FrameLen);

	logic [PosW-1:0] pos_q;
	logic [PosW-1:0] pos_eff;
	logic [7:0]      store_q [FrameLen];
	logic            completes;
	logic            accept;
	logic            write;

	always_comb begin
		pos_eff   = frame_start ? '0 : pos_q;
		completes = (pos_eff == LastPos);
		in_ready  = !(completes && q_stat.full);
		accept    = in_valid && in_ready;
		write     = accept && (pos_eff < EndPos);
		push      = write && completes;
		for (int i = 0; i < FrameLen - 1; i++) begin
			push_frame[i] = store_q[i];
		end
		push_frame[FrameLen-1] = rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (write) begin
				pos_q <= pos_eff + PosW'(1);
			end else begin
				pos_q <= pos_eff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (write) begin
			store_q[pos_eff] <= rx_byte;
		end
	end

endmodule

@@ design/mfd_queue.sv @@
// Two-entry frame queue between the assembler and the decoder.
module mfd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mfd_pkg::frame_t  push_frame,
	input  logic             pop,
	output mfd_pkg::frame_t  head_frame,
	output mfd_pkg::q_stat_t q_stat
);
	import mfd_pkg::*;

	localparam int PtrW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);

	frame_t          mem_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	always_comb begin
		q_stat.full  = (cnt_q == CntW'(QueueDepth));
		q_stat.empty = (cnt_q == '0);
		do_push      = push && !q_stat.full;
		do_pop       = pop && !q_stat.empty;
		head_frame   = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_frame;
		end
	end

endmodule

@@ design/mfd_back.sv @@
// Frame decoder: turns a queued frame into one registered result.
module mfd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  mfd_pkg::frame_t  head_frame,
	input  mfd_pkg::q_stat_t q_stat,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       status,
	output logic [3:0]       mode_code,
	output logic [2:0]       scale_code,
	output logic [2:0]       unit_code,
	output logic [2:0]       decimal_places,
	output logic [16:0]      magnitude,
	output logic             negative,
	output logic [11:0]      option_flags
);
	import mfd_pkg::*;

	localparam logic [2:0] StOk       = 3'd0;
	localparam logic [2:0] StNoCrlf   = 3'd1;
	localparam logic [2:0] StBadFunc  = 3'd2;
	localparam logic [2:0] StBadRange = 3'd3;
	localparam logic [2:0] StEmpty    = 3'd4;
	localparam logic [2:0] StBadDigit = 3'd5;

	localparam logic [7:0] CodeVolt = 8'h3B;
	localparam logic [7:0] CodeUa   = 8'h3D;
	localparam logic [7:0] CodeMa   = 8'h3F;
	localparam logic [7:0] Code22a  = 8'h30;
	localparam logic [7:0] CodeOhm  = 8'h33;
	localparam logic [7:0] CodeCont = 8'h35;
	localparam logic [7:0] CodeDiod = 8'h31;
	localparam logic [7:0] CodeFreq = 8'h32;
	localparam logic [7:0] CodeCap  = 8'h36;
	localparam logic [7:0] ChCr     = 8'h0D;
	localparam logic [7:0] ChLf     = 8'h0A;
	localparam logic [7:0] ChZero   = 8'h30;
	localparam logic [7:0] ChSeven  = 8'h37;
	localparam logic [7:0] ChNine   = 8'h39;

	localparam logic [3:0] ModeVolt  = 4'd0;
	localparam logic [3:0] ModeMv    = 4'd1;
	localparam logic [3:0] ModeUa    = 4'd2;
	localparam logic [3:0] ModeMa    = 4'd3;
	localparam logic [3:0] Mode22a   = 4'd4;
	localparam logic [3:0] ModeOhm   = 4'd5;
	localparam logic [3:0] ModeCont  = 4'd6;
	localparam logic [3:0] ModeDiod  = 4'd7;
	localparam logic [3:0] ModeHz    = 4'd8;
	localparam logic [3:0] ModeCap   = 4'd9;
	localparam logic [3:0] ModeAltHz = 4'd10;
	localparam logic [3:0] ModeDuty  = 4'd11;

	localparam logic [2:0] ScNone  = 3'd0;
	localparam logic [2:0] ScNano  = 3'd1;
	localparam logic [2:0] ScMicro = 3'd2;
	localparam logic [2:0] ScMilli = 3'd3;
	localparam logic [2:0] ScKilo  = 3'd4;
	localparam logic [2:0] ScMega  = 3'd5;

	localparam logic [2:0] UnVolt = 3'd0;
	localparam logic [2:0] UnAmp  = 3'd1;
	localparam logic [2:0] UnOhm  = 3'd2;
	localparam logic [2:0] UnHz   = 3'd3;
	localparam logic [2:0] UnFar  = 3'd4;
	localparam logic [2:0] UnPct  = 3'd5;

	typedef struct packed {
		logic       ok;
		logic [2:0] dec;
		logic [2:0] scale;
		logic [2:0] unit;
	} range_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  mode;
		logic [2:0]  scale;
		logic [2:0]  unit;
		logic [2:0]  dec;
		logic [16:0] mag;
		logic        neg;
		logic [11:0] opts;
	} result_t;

	function automatic range_t rng(input logic [2:0] dec, input logic [2:0] scale,
			input logic [2:0] unit);
		range_t r;
		r.ok    = 1'b1;
		r.dec   = dec;
		r.scale = scale;
		r.unit  = unit;
		return r;
	endfunction

	function automatic range_t range_lookup(input logic [3:0] mode, input logic [2:0] rd);
		range_t r;
		r = '0;
		unique case (mode)
			ModeVolt: begin
				unique case (rd)
					3'd0:    r = rng(3'd4, ScNone, UnVolt);
					3'd1:    r = rng(3'd3, ScNone, UnVolt);
					3'd2:    r = rng(3'd2, ScNone, UnVolt);
					3'd3:    r = rng(3'd1, ScNone, UnVolt);
					3'd4:    r = rng(3'd2, ScMilli, UnVolt);
					default: r = '0;
				endcase
			end
			ModeUa: begin
				unique case (rd)
					3'd0:    r = rng(3'd2, ScMicro, UnAmp);
					3'd1:    r = rng(3'd1, ScMicro, UnAmp);
					default: r = '0;
				endcase
			end
			ModeMa: begin
				unique case (rd)
					3'd0:    r = rng(3'd3, ScMilli, UnAmp);
					3'd1:    r = rng(3'd2, ScMilli, UnAmp);
					default: r = '0;
				endcase
			end
			Mode22a: begin
				if (rd == 3'd0) begin
					r = rng(3'd3, ScNone, UnAmp);
				end
			end
			ModeOhm: begin
				unique case (rd)
					3'd0:    r = rng(3'd2, ScNone, UnOhm);
					3'd1:    r = rng(3'd4, ScKilo, UnOhm);
					3'd2:    r = rng(3'd3, ScKilo, UnOhm);
					3'd3:    r = rng(3'd2, ScKilo, UnOhm);
					3'd4:    r = rng(3'd4, ScMega, UnOhm);
					3'd5:    r = rng(3'd3, ScMega, UnOhm);
					3'd6:    r = rng(3'd2, ScMega, UnOhm);
					default: r = '0;
				endcase
			end
			ModeCont: begin
				if (rd == 3'd0) begin
					r = rng(3'd2, ScNone, UnOhm);
				end
			end
			ModeDiod: begin
				if (rd == 3'd0) begin
					r = rng(3'd4, ScNone, UnVolt);
				end
			end
			ModeHz: begin
				unique case (rd)
					3'd0:    r = rng(3'd2, ScNone, UnHz);
					3'd1:    r = rng(3'd1, ScNone, UnHz);
					3'd3:    r = rng(3'd3, ScKilo, UnHz);
					3'd4:    r = rng(3'd2, ScKilo, UnHz);
					3'd5:    r = rng(3'd4, ScMega, UnHz);
					3'd6:    r = rng(3'd3, ScMega, UnHz);
					3'd7:    r = rng(3'd2, ScMega, UnHz);
					default: r = '0;
				endcase
			end
			ModeCap: begin
				unique case (rd)
					3'd0:    r = rng(3'd3, ScNano, UnFar);
					3'd1:    r = rng(3'd2, ScNano, UnFar);
					3'd2:    r = rng(3'd4, ScMicro, UnFar);
					3'd3:    r = rng(3'd3, ScMicro, UnFar);
					3'd4:    r = rng(3'd2, ScMicro, UnFar);
					3'd5:    r = rng(3'd4, ScMilli, UnFar);
					3'd6:    r = rng(3'd3, ScMilli, UnFar);
					default: r = rng(3'd2, ScMilli, UnFar);
				endcase
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	frame_t      f;
	result_t     res;
	result_t     res_q;
	logic        out_valid_q;
	logic [11:0] opts;
	logic        judge;
	logic        vahz;
	logic        func_ok;
	logic [3:0]  func_mode;
	range_t      r;
	logic [3:0]  mode;
	logic        range_digit_ok;
	logic        digits_ok;
	logic [3:0]  dg [5];
	logic [16:0] val;

	always_comb begin
		f = head_frame;
		opts = {f[8][2], f[8][3], f[9][3], f[7][0], f[9][1], f[9][2],
			f[8][1], f[11][1], f[10][1], f[10][2], f[10][3], f[7][1]};
		judge = f[7][3];
		vahz  = f[10][0];

		func_ok   = 1'b1;
		func_mode = ModeVolt;
		unique case (f[6])
			CodeVolt: func_mode = ModeVolt;
			CodeUa:   func_mode = ModeUa;
			CodeMa:   func_mode = ModeMa;
			Code22a:  func_mode = Mode22a;
			CodeOhm:  func_mode = ModeOhm;
			CodeCont: func_mode = ModeCont;
			CodeDiod: func_mode = ModeDiod;
			CodeFreq: func_mode = ModeHz;
			CodeCap:  func_mode = ModeCap;
			default:  func_ok   = 1'b0;
		endcase

		range_digit_ok = 1'b1;
		priority if (vahz && !judge) begin
			r    = rng(3'd1, ScNone, UnHz);
			mode = ModeAltHz;
		end else if ((vahz || f[6] == CodeFreq) && judge) begin
			r    = rng(3'd1, ScNone, UnPct);
			mode = ModeDuty;
		end else begin
			range_digit_ok = (f[0] >= ChZero) && (f[0] <= ChSeven);
			r    = range_lookup(func_mode, f[0][2:0]);
			mode = func_mode;
			if (f[6] == CodeVolt && r.scale == ScMilli) begin
				mode = ModeMv;
			end
		end

		digits_ok = 1'b1;
		for (int i = 0; i < 5; i++) begin
			dg[i] = f[i+1][3:0];
			if (f[i+1] < ChZero || f[i+1] > ChNine) begin
				digits_ok = 1'b0;
			end
		end
		val = 17'(dg[0]) * 17'd10000 + 17'(dg[1]) * 17'd1000 + 17'(dg[2]) * 17'd100
			+ 17'(dg[3]) * 17'd10 + 17'(dg[4]);

		res = '0;
		priority if (f[12] != ChCr || f[13] != ChLf) begin
			res.status = StNoCrlf;
		end else if (!func_ok) begin
			res.status = StBadFunc;
		end else if (!range_digit_ok) begin
			res.status = StBadRange;
		end else if (!r.ok) begin
			res.status = StEmpty;
		end else if (opts[8] || opts[9]) begin
			res.status = StOk;
			res.mode   = mode;
			res.scale  = r.scale;
			res.unit   = r.unit;
			res.opts   = opts;
		end else if (!digits_ok) begin
			res.status = StBadDigit;
		end else begin
			res.status = StOk;
			res.mode   = mode;
			res.scale  = r.scale;
			res.unit   = r.unit;
			res.dec    = r.dec;
			res.mag    = val;
			res.neg    = f[7][2];
			res.opts   = opts;
		end

		pop = !q_stat.empty && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = res_q.status;
	assign mode_code      = res_q.mode;
	assign scale_code     = res_q.scale;
	assign unit_code      = res_q.unit;
	assign decimal_places = res_q.dec;
	assign magnitude      = res_q.mag;
	assign negative       = res_q.neg;
	assign option_flags   = res_q.opts;

endmodule

@@ design/meter_frame_decoder_core.sv @@
// Top level of the meter frame decoder: assembler, frame queue and decoder.
// The block takes one report byte per cycle while in_ready is high and gives one
// decoded result for every 14-byte frame; out_valid rises once the result is
// registered, when the output is free. The assembler holds the frame bytes and passes
// a completed frame to a two-entry queue; the decoder empties that queue into a single
// output register. Input ready falls only for a byte that would complete a frame while
// both queue entries are taken, so with the output stalled the block still takes every
// byte up to that point. The byte store holds no defined values until written.
module meter_frame_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        frame_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [3:0]  mode_code,
	output logic [2:0]  scale_code,
	output logic [2:0]  unit_code,
	output logic [2:0]  decimal_places,
	output logic [16:0] magnitude,
	output logic        negative,
	output logic [11:0] option_flags
);
	import mfd_pkg::*;

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	frame_t  push_frame;
	frame_t  head_frame;

	mfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.frame_start(frame_start),
		.q_stat     (q_stat),
		.push       (push),
		.push_frame (push_frame)
	);

	mfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_frame(push_frame),
		.pop       (pop),
		.head_frame(head_frame),
		.q_stat    (q_stat)
	);

	mfd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_frame    (head_frame),
		.q_stat        (q_stat),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.mode_code     (mode_code),
		.scale_code    (scale_code),
		.unit_code     (unit_code),
		.decimal_places(decimal_places),
		.magnitude     (magnitude),
		.negative      (negative),
		.option_flags  (option_flags)
	);

endmodule

@@ verif/meter_frame_decoder_core_test.sv @@
// Self-checking testbench for meter_frame_decoder_core: directed and random report frames.
module meter_frame_decoder_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	import mfd_pkg::FrameLen;
	import mfd_pkg::frame_t;

	localparam int CycleLimit  = 400000;
	localparam int RandomBytes = 1000;
	localparam int DrainCycles = 20;

	localparam logic [7:0] CHAR_0  = 8'h30;
	localparam logic [7:0] CHAR_7  = 8'h37;
	localparam logic [7:0] CHAR_9  = 8'h39;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] FLAGS_CLEAR = 8'h30;

	localparam logic [7:0] FN_VOLT  = 8'h3B;
	localparam logic [7:0] FN_UA    = 8'h3D;
	localparam logic [7:0] FN_MA    = 8'h3F;
	localparam logic [7:0] FN_22A   = 8'h30;
	localparam logic [7:0] FN_OHM   = 8'h33;
	localparam logic [7:0] FN_CONT  = 8'h35;
	localparam logic [7:0] FN_DIO   = 8'h31;
	localparam logic [7:0] FN_FREQ  = 8'h32;
	localparam logic [7:0] FN_CAP   = 8'h36;

	typedef enum logic [2:0] {
		ST_OK, ST_NO_CRLF, ST_BAD_FUNC, ST_BAD_RANGE, ST_EMPTY_RANGE, ST_BAD_DIGIT
	} status_e;

	typedef enum logic [3:0] {
		MODE_VOLT, MODE_MVOLT, MODE_UA, MODE_MA, MODE_22A, MODE_OHM,
		MODE_CONT, MODE_DIODE, MODE_HZ, MODE_CAP, MODE_ALT_HZ, MODE_DUTY
	} mode_e;

	typedef enum logic [2:0] {SC_NONE, SC_NANO, SC_MICRO, SC_MILLI, SC_KILO, SC_MEGA} scale_e;
	typedef enum logic [2:0] {UN_VOLT, UN_AMP, UN_OHM, UN_HZ, UN_FARAD, UN_PCT} unit_e;

	typedef struct packed {
		status_e     st;
		mode_e       mode;
		scale_e      scale;
		unit_e       unit;
		logic [2:0]  dec;
		logic [16:0] mag;
		logic        neg;
		logic [11:0] opts;
	} reading_t;

	typedef struct packed {
		logic       ok;
		mode_e      mode;
		logic [2:0] dec;
		scale_e     scale;
		unit_e      unit;
	} span_t;

	typedef struct {
		frame_t   bytes;
		bit       first_start;
		int       lead;
		int       after;
		bit       typed;
		reading_t want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        frame_start = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [3:0]  mode_code;
	logic [2:0]  scale_code;
	logic [2:0]  unit_code;
	logic [2:0]  decimal_places;
	logic [16:0] magnitude;
	logic        negative;
	logic [11:0] option_flags;

	frame_t   captured;
	int       fill_pos = 0;
	reading_t expected_readings[$];
	row_t     quoted_frames[$];
	row_t     script[$];
	int       mismatch_count = 0;
	int       cycle_count = 0;
	bit       src_calm = 1'b0;
	bit       sink_calm = 1'b0;
	int       sink_hold = 0;

	meter_frame_decoder_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.rx_byte(rx_byte), .frame_start(frame_start),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .mode_code(mode_code), .scale_code(scale_code),
		.unit_code(unit_code), .decimal_places(decimal_places),
		.magnitude(magnitude), .negative(negative), .option_flags(option_flags)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic span_t ent(span_t s, logic [2:0] dec, scale_e sc, unit_e un);
		s.ok = 1'b1;
		s.dec = dec;
		s.scale = sc;
		s.unit = un;
		return s;
	endfunction

	function automatic bit func_known(logic [7:0] fn);
		case (fn)
			FN_VOLT, FN_UA, FN_MA, FN_22A, FN_OHM, FN_CONT, FN_DIO, FN_FREQ, FN_CAP: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic span_t span_of(logic [7:0] fn, logic [2:0] r);
		span_t s;
		s = '0;
		case (fn)
			FN_VOLT: begin
				s.mode = MODE_VOLT;
				case (r)
					3'd0: s = ent(s, 4, SC_NONE, UN_VOLT);
					3'd1: s = ent(s, 3, SC_NONE, UN_VOLT);
					3'd2: s = ent(s, 2, SC_NONE, UN_VOLT);
					3'd3: s = ent(s, 1, SC_NONE, UN_VOLT);
					3'd4: s = ent(s, 2, SC_MILLI, UN_VOLT);
					default: ;
				endcase
			end
			FN_UA: begin
				s.mode = MODE_UA;
				case (r)
					3'd0: s = ent(s, 2, SC_MICRO, UN_AMP);
					3'd1: s = ent(s, 1, SC_MICRO, UN_AMP);
					default: ;
				endcase
			end
			FN_MA: begin
				s.mode = MODE_MA;
				case (r)
					3'd0: s = ent(s, 3, SC_MILLI, UN_AMP);
					3'd1: s = ent(s, 2, SC_MILLI, UN_AMP);
					default: ;
				endcase
			end
			FN_22A: begin
				s.mode = MODE_22A;
				if (r == 3'd0) s = ent(s, 3, SC_NONE, UN_AMP);
			end
			FN_OHM: begin
				s.mode = MODE_OHM;
				case (r)
					3'd0: s = ent(s, 2, SC_NONE, UN_OHM);
					3'd1: s = ent(s, 4, SC_KILO, UN_OHM);
					3'd2: s = ent(s, 3, SC_KILO, UN_OHM);
					3'd3: s = ent(s, 2, SC_KILO, UN_OHM);
					3'd4: s = ent(s, 4, SC_MEGA, UN_OHM);
					3'd5: s = ent(s, 3, SC_MEGA, UN_OHM);
					3'd6: s = ent(s, 2, SC_MEGA, UN_OHM);
					default: ;
				endcase
			end
			FN_CONT: begin
				s.mode = MODE_CONT;
				if (r == 3'd0) s = ent(s, 2, SC_NONE, UN_OHM);
			end
			FN_DIO: begin
				s.mode = MODE_DIODE;
				if (r == 3'd0) s = ent(s, 4, SC_NONE, UN_VOLT);
			end
			FN_FREQ: begin
				s.mode = MODE_HZ;
				case (r)
					3'd0: s = ent(s, 2, SC_NONE, UN_HZ);
					3'd1: s = ent(s, 1, SC_NONE, UN_HZ);
					3'd3: s = ent(s, 3, SC_KILO, UN_HZ);
					3'd4: s = ent(s, 2, SC_KILO, UN_HZ);
					3'd5: s = ent(s, 4, SC_MEGA, UN_HZ);
					3'd6: s = ent(s, 3, SC_MEGA, UN_HZ);
					3'd7: s = ent(s, 2, SC_MEGA, UN_HZ);
					default: ;
				endcase
			end
			FN_CAP: begin
				s.mode = MODE_CAP;
				case (r)
					3'd0: s = ent(s, 3, SC_NANO, UN_FARAD);
					3'd1: s = ent(s, 2, SC_NANO, UN_FARAD);
					3'd2: s = ent(s, 4, SC_MICRO, UN_FARAD);
					3'd3: s = ent(s, 3, SC_MICRO, UN_FARAD);
					3'd4: s = ent(s, 2, SC_MICRO, UN_FARAD);
					3'd5: s = ent(s, 4, SC_MILLI, UN_FARAD);
					3'd6: s = ent(s, 3, SC_MILLI, UN_FARAD);
					3'd7: s = ent(s, 2, SC_MILLI, UN_FARAD);
				endcase
			end
			default: ;
		endcase
		return s;
	endfunction

	function automatic reading_t fault(status_e st);
		reading_t res;
		res = '0;
		res.st = st;
		return res;
	endfunction

	function automatic reading_t decode_frame(frame_t f);
		reading_t    res;
		span_t       sp;
		logic [11:0] opts;
		logic        judge;
		logic        vahz;
		int          val;
		res = '0;
		sp = '0;
		val = 0;
		if (f[12] != CHAR_CR || f[13] != CHAR_LF) return fault(ST_NO_CRLF);
		opts = {f[8][2], f[8][3], f[9][3], f[7][0], f[9][1], f[9][2],
			f[8][1], f[11][1], f[10][1], f[10][2], f[10][3], f[7][1]};
		judge = f[7][3];
		vahz = f[10][0];
		if (!func_known(f[6])) return fault(ST_BAD_FUNC);
		if (vahz && !judge) begin
			sp.mode = MODE_ALT_HZ;
			sp = ent(sp, 1, SC_NONE, UN_HZ);
		end else if ((vahz || f[6] == FN_FREQ) && judge) begin
			sp.mode = MODE_DUTY;
			sp = ent(sp, 1, SC_NONE, UN_PCT);
		end else begin
			if (f[0] < CHAR_0 || f[0] > CHAR_7) return fault(ST_BAD_RANGE);
			sp = span_of(f[6], f[0][2:0]);
			if (f[6] == FN_VOLT && sp.scale == SC_MILLI) sp.mode = MODE_MVOLT;
		end
		if (!sp.ok) return fault(ST_EMPTY_RANGE);
		res.mode = sp.mode;
		res.scale = sp.scale;
		res.unit = sp.unit;
		res.opts = opts;
		// Over or under limit: reading fields stay zero and digits go unchecked.
		if (opts[8] || opts[9]) return res;
		for (int i = 1; i <= 5; i++) begin
			if (f[i] < CHAR_0 || f[i] > CHAR_9) return fault(ST_BAD_DIGIT);
			val = val * 10 + int'(f[i] - CHAR_0);
		end
		res.dec = sp.dec;
		res.mag = 17'(val);
		res.neg = f[7][2];
		return res;
	endfunction

	function automatic frame_t mk_frame(logic [7:0] rng, int val, logic [7:0] fn);
		frame_t f;
		f[0] = rng;
		for (int i = 5; i >= 1; i--) begin
			f[i] = 8'(CHAR_0 + val % 10);
			val = val / 10;
		end
		f[6] = fn;
		for (int i = 7; i <= 11; i++) f[i] = FLAGS_CLEAR;
		f[12] = CHAR_CR;
		f[13] = CHAR_LF;
		return f;
	endfunction

	function automatic frame_t random_frame();
		frame_t f;
		logic [7:0] fn;
		case ($urandom_range(0, 9))
			0: fn = FN_VOLT;
			1: fn = FN_UA;
			2: fn = FN_MA;
			3: fn = FN_22A;
			4: fn = FN_OHM;
			5: fn = FN_CONT;
			6: fn = FN_DIO;
			7: fn = FN_FREQ;
			8: fn = FN_CAP;
			default: fn = 8'($urandom);
		endcase
		f = mk_frame(8'(CHAR_0 + $urandom_range(0, 7)), $urandom_range(0, 99999), fn);
		if ($urandom_range(0, 7) == 0) f[0] = 8'($urandom);
		for (int i = 1; i <= 5; i++) begin
			if ($urandom_range(0, 31) == 0) f[i] = 8'($urandom);
		end
		for (int i = 7; i <= 11; i++) begin
			f[i] = {4'h3, 4'($urandom)};
			if ($urandom_range(0, 15) == 0) f[i] = 8'($urandom);
		end
		if ($urandom_range(0, 3) != 0) begin
			f[7][0] = 1'b0;
			f[9][3] = 1'b0;
		end
		if ($urandom_range(0, 1) == 0) f[7][3] = 1'b0;
		if ($urandom_range(0, 1) == 0) f[10][0] = 1'b0;
		if ($urandom_range(0, 15) == 0) f[12 + $urandom_range(0, 1)] = 8'($urandom);
		return f;
	endfunction

	function automatic reading_t ok_reading(mode_e m, scale_e sc, unit_e un, logic [2:0] dec,
			logic [16:0] mag, logic neg);
		reading_t res;
		res = '0;
		res.mode = m;
		res.scale = sc;
		res.unit = un;
		res.dec = dec;
		res.mag = mag;
		res.neg = neg;
		return res;
	endfunction

	function automatic row_t make_row(frame_t f, bit first_start, int lead, int after,
			bit typed, reading_t want);
		row_t r;
		r.bytes = f;
		r.first_start = first_start;
		r.lead = lead;
		r.after = after;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	function automatic row_t plain(frame_t f);
		return make_row(f, 1'b1, 0, 0, 1'b0, '0);
	endfunction

	function automatic row_t quoted(frame_t f, reading_t want);
		return make_row(f, 1'b1, 0, 0, 1'b1, want);
	endfunction

	task automatic send(input logic [7:0] b, input logic s);
		int gap;
		if ($urandom_range(0, 15) == 0) src_calm = !src_calm;
		gap = src_calm ? 0 : int'($urandom_range(0, 16));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		frame_start <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_readings.size() != 0) @(posedge clk);
	endtask

	task automatic take_byte(input logic [7:0] b, input logic s);
		reading_t r;
		row_t     q;
		if (s) fill_pos = 0;
		if (fill_pos < FrameLen) begin
			captured[fill_pos] = b;
			fill_pos++;
			if (fill_pos == FrameLen) begin
				r = decode_frame(captured);
				if (quoted_frames.size() != 0) begin
					q = quoted_frames.pop_front();
					if (q.typed) r = q.want;
				end
				expected_readings.push_back(r);
			end
		end
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic check_reading();
		reading_t want;
		if (expected_readings.size() == 0) begin
			$display("%0t ns: unexpected result, expected none, actual status %0d magnitude %0d",
				$time, status, magnitude);
			mismatch_count++;
		end else begin
			want = expected_readings.pop_front();
			compare_field("status", want.st, status);
			compare_field("mode_code", want.mode, mode_code);
			compare_field("scale_code", want.scale, scale_code);
			compare_field("unit_code", want.unit, unit_code);
			compare_field("decimal_places", want.dec, decimal_places);
			compare_field("magnitude", want.mag, magnitude);
			compare_field("negative", want.neg, negative);
			compare_field("option_flags", want.opts, option_flags);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) take_byte(rx_byte, frame_start);
			if (out_valid && out_ready) check_reading();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if ($urandom_range(0, 15) == 0) sink_calm = !sink_calm;
				sink_hold = sink_calm ? 0 : int'($urandom_range(0, 16));
			end
			if (sink_hold > 0) begin
				out_ready <= 1'b0;
				sink_hold--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("** meter_frame_decoder_core: FAILED **");
			$finish;
		end
	end

	initial begin
		frame_t fr;
		int     n;
		int     sent;
		bit     drained;
		sent = 0;
		drained = 1'b0;

		// The first frame after reset carries no start flag.
		fr = mk_frame(CHAR_0, 12345, FN_VOLT);
		script.push_back(make_row(fr, 1'b0, 0, 0, 1'b1,
			ok_reading(MODE_VOLT, SC_NONE, UN_VOLT, 4, 12345, 1'b0)));
		fr = mk_frame(CHAR_0, 99999, FN_VOLT);
		fr[7] = 8'h34;
		script.push_back(quoted(fr, ok_reading(MODE_VOLT, SC_NONE, UN_VOLT, 4, 99999, 1'b1)));
		fr = mk_frame(8'h33, 0, FN_VOLT);
		script.push_back(quoted(fr, ok_reading(MODE_VOLT, SC_NONE, UN_VOLT, 1, 0, 1'b0)));

		fr = mk_frame(CHAR_0, 11111, FN_VOLT);
		fr[13] = CHAR_CR;
		script.push_back(quoted(fr, fault(ST_NO_CRLF)));
		fr = mk_frame(CHAR_0, 22222, 8'h3A);
		fr[10] = 8'h31;
		script.push_back(quoted(fr, fault(ST_BAD_FUNC)));
		script.push_back(quoted(mk_frame(CHAR_0, 33333, 8'h00), fault(ST_BAD_FUNC)));
		script.push_back(quoted(mk_frame(8'h38, 44444, FN_VOLT), fault(ST_BAD_RANGE)));
		script.push_back(quoted(mk_frame(8'hFF, 55555, FN_OHM), fault(ST_BAD_RANGE)));
		script.push_back(quoted(mk_frame(8'h32, 66666, FN_UA), fault(ST_EMPTY_RANGE)));
		fr = mk_frame(CHAR_0, 77777, FN_VOLT);
		fr[3] = 8'h3A;
		script.push_back(quoted(fr, fault(ST_BAD_DIGIT)));

		script.push_back(plain(mk_frame(8'h34, $urandom_range(0, 99999), FN_VOLT)));
		script.push_back(plain(mk_frame(8'h31, $urandom_range(0, 99999), FN_UA)));
		script.push_back(plain(mk_frame(CHAR_0, $urandom_range(0, 99999), FN_MA)));
		script.push_back(plain(mk_frame(CHAR_0, $urandom_range(0, 99999), FN_22A)));
		script.push_back(plain(mk_frame(8'h36, $urandom_range(0, 99999), FN_OHM)));
		script.push_back(plain(mk_frame(CHAR_0, $urandom_range(0, 99999), FN_CONT)));
		script.push_back(plain(mk_frame(CHAR_0, $urandom_range(0, 99999), FN_DIO)));
		script.push_back(plain(mk_frame(CHAR_7, $urandom_range(0, 99999), FN_FREQ)));
		script.push_back(plain(mk_frame(CHAR_7, $urandom_range(0, 99999), FN_CAP)));

		// Every option flag set, over limit, with a digit that is not checked.
		fr = mk_frame(CHAR_0, 0, FN_VOLT);
		fr[2] = 8'hFF;
		fr[7] = 8'h37;
		fr[8] = 8'h3E;
		fr[9] = 8'h3E;
		fr[10] = 8'h3E;
		fr[11] = 8'h32;
		script.push_back(plain(fr));
		fr = mk_frame(8'h31, 12, FN_OHM);
		fr[9] = 8'h38;
		script.push_back(plain(fr));

		fr = mk_frame(8'h39, $urandom_range(0, 99999), FN_VOLT);
		fr[10] = 8'h31;
		script.push_back(plain(fr));
		fr = mk_frame(8'h39, $urandom_range(0, 99999), FN_FREQ);
		fr[7] = 8'h38;
		script.push_back(plain(fr));
		fr = mk_frame(CHAR_0, $urandom_range(0, 99999), FN_CAP);
		fr[7] = 8'h38;
		fr[10] = 8'h31;
		script.push_back(plain(fr));

		script.push_back(make_row(mk_frame(8'h32, 31415, FN_OHM), 1'b1, 5, 0, 1'b0, '0));
		script.push_back(make_row(mk_frame(8'h33, 27182, FN_CAP), 1'b1, 0, 3, 1'b0, '0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			quoted_frames.push_back(script[i]);
			for (int k = 0; k < script[i].lead; k++) send(8'($urandom), k == 0);
			for (int k = 0; k < FrameLen; k++) begin
				send(script[i].bytes[k], k == 0 && script[i].first_start);
			end
			for (int k = 0; k < script[i].after; k++) send(8'($urandom), 1'b0);
		end

		while (sent < RandomBytes) begin
			if ($urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, FrameLen - 1);
				for (int k = 0; k < n; k++) send(8'($urandom), k == 0);
			end
			fr = random_frame();
			for (int k = 0; k < FrameLen; k++) send(fr[k], k == 0);
			sent += FrameLen;
			if ($urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 4);
				for (int k = 0; k < n; k++) send(8'($urandom), $urandom_range(0, 7) == 0);
			end
			if (!drained && sent >= RandomBytes / 2) begin
				drained = 1'b1;
				wait_drained();
			end
		end

		wait_drained();
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0 && expected_readings.size() == 0) begin
			$display("** meter_frame_decoder_core: PASSED **");
		end else begin
			$display("** meter_frame_decoder_core: FAILED **");
		end
		$finish;
	end

endmodule

@@ files.f @@
design/mfd_pkg.sv
design/mfd_front.sv
design/mfd_queue.sv
design/mfd_back.sv
design/meter_frame_decoder_core.sv
verif/meter_frame_decoder_core_test.sv
